// ===== rtl/acsp_pkg.sv =====
// acsp_pkg: character codes, parser codes and the result record shared by
// the SET command line parser core and its line-state module.
// No dependencies.
`timescale 1ns / 1ps

package acsp_pkg;

	localparam int SETTING_COUNT = 7;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_VT    = 8'h0B;
	localparam logic [7:0] CHAR_FF    = 8'h0C;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UP_S  = 8'h53;
	localparam logic [7:0] CHAR_UP_E  = 8'h45;
	localparam logic [7:0] CHAR_UP_T  = 8'h54;

	// header match progress through "SET"
	localparam logic [2:0] HDR_NONE = 3'd0;
	localparam logic [2:0] HDR_S    = 3'd1;
	localparam logic [2:0] HDR_SE   = 3'd2;
	localparam logic [2:0] HDR_SET  = 3'd3;
	localparam logic [2:0] HDR_BAD  = 3'd4;

	// number scan phase
	localparam logic [1:0] PH_SPACE = 2'd0;
	localparam logic [1:0] PH_SIGN  = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;
	localparam logic [1:0] PH_STOP  = 2'd3;

	// line status codes
	localparam logic [1:0] ST_ALL     = 2'd0;
	localparam logic [1:0] ST_PARTIAL = 2'd1;
	localparam logic [1:0] ST_NO_HDR  = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	// token count saturates one past the last setting
	localparam logic [3:0] TOKEN_SAT = 4'd8;

	typedef struct packed {
		logic [SETTING_COUNT-1:0][7:0] settings;
		logic [2:0]                    fields;
		logic [1:0]                    status;
	} result_t;

endpackage

// ===== rtl/acsp_line_state.sv =====
// acsp_line_state: per-line parse state and the seven settings, updated by
// one byte per step, plus the result record for a newline byte.
// Depends on acsp_pkg.
`timescale 1ns / 1ps

module acsp_line_state #(
	parameter int LINE_LIMIT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_char,
	output acsp_pkg::result_t res
);

	localparam int LEN_W = $clog2(LINE_LIMIT);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_LIMIT - 1);

	logic [LEN_W-1:0] len_q, len_d;
	logic             ended_q, ended_d;
	logic [3:0]       tn_q, tn_d;
	logic             intok_q, intok_d;
	logic [2:0]       hm_q, hm_d;
	logic [1:0]       ph_q, ph_d;
	logic             neg_q, neg_d;
	logic [7:0]       acc_q, acc_d;
	logic [acsp_pkg::SETTING_COUNT-1:0][7:0] set_q, set_d;

	always_comb begin
		logic       is_lf;
		logic       kept;
		logic       close_req;
		logic       take_req;
		logic [7:0] val;
		logic [2:0] idx;
		logic [2:0] fields;
		logic [1:0] status;

		len_d   = len_q;
		ended_d = ended_q;
		tn_d    = tn_q;
		intok_d = intok_q;
		hm_d    = hm_q;
		ph_d    = ph_q;
		neg_d   = neg_q;
		acc_d   = acc_q;
		set_d   = set_q;

		is_lf = (rx_char == acsp_pkg::CHAR_LF);
		kept  = !is_lf && (rx_char != acsp_pkg::CHAR_CR) && (len_q < LEN_MAX);
		close_req = step && !ended_q && (is_lf || (kept &&
			(rx_char == acsp_pkg::CHAR_NUL || rx_char == acsp_pkg::CHAR_COMMA)));
		take_req = step && kept && !ended_q &&
			(rx_char != acsp_pkg::CHAR_NUL) && (rx_char != acsp_pkg::CHAR_COMMA);

		if (step && kept) begin
			len_d = len_q + LEN_W'(1);
			if (!ended_q && rx_char == acsp_pkg::CHAR_NUL)
				ended_d = 1'b1;
		end

		// finish the token in progress and store its value
		val = neg_q ? (8'd0 - acc_q) : acc_q;
		idx = 3'(tn_q - 4'd1);
		if (close_req && intok_q) begin
			intok_d = 1'b0;
			if (tn_q == 4'd0) begin
				tn_d = 4'd1;
			end else if (tn_q < acsp_pkg::TOKEN_SAT) begin
				tn_d = tn_q + 4'd1;
				if (hm_q == acsp_pkg::HDR_SET)
					set_d[idx] = val;
			end
		end

		if (take_req) begin
			if (!intok_q) begin
				intok_d = 1'b1;
				ph_d    = acsp_pkg::PH_SPACE;
				neg_d   = 1'b0;
				acc_d   = 8'd0;
			end
			if (tn_q == 4'd0) begin
				if (hm_q == acsp_pkg::HDR_NONE && rx_char == acsp_pkg::CHAR_UP_S)
					hm_d = acsp_pkg::HDR_S;
				else if (hm_q == acsp_pkg::HDR_S && rx_char == acsp_pkg::CHAR_UP_E)
					hm_d = acsp_pkg::HDR_SE;
				else if (hm_q == acsp_pkg::HDR_SE && rx_char == acsp_pkg::CHAR_UP_T)
					hm_d = acsp_pkg::HDR_SET;
				else
					hm_d = acsp_pkg::HDR_BAD;
			end else if (ph_d == acsp_pkg::PH_STOP) begin
				ph_d = acsp_pkg::PH_STOP;
			end else if (ph_d == acsp_pkg::PH_SPACE &&
					(rx_char == acsp_pkg::CHAR_SPACE || rx_char == acsp_pkg::CHAR_TAB ||
					rx_char == acsp_pkg::CHAR_VT || rx_char == acsp_pkg::CHAR_FF)) begin
				ph_d = acsp_pkg::PH_SPACE;
			end else if (ph_d == acsp_pkg::PH_SPACE &&
					(rx_char == acsp_pkg::CHAR_PLUS || rx_char == acsp_pkg::CHAR_MINUS)) begin
				neg_d = (rx_char == acsp_pkg::CHAR_MINUS);
				ph_d  = acsp_pkg::PH_SIGN;
			end else if (rx_char >= acsp_pkg::CHAR_ZERO && rx_char <= acsp_pkg::CHAR_NINE) begin
				// acc * 10 + digit, modulo 256
				acc_d = {acc_d[4:0], 3'b000} + {acc_d[6:0], 1'b0} +
					(rx_char - acsp_pkg::CHAR_ZERO);
				ph_d  = acsp_pkg::PH_DIGIT;
			end else begin
				ph_d = acsp_pkg::PH_STOP;
			end
		end

		// status from the state after the closing token
		fields = 3'd0;
		if (len_q == '0) begin
			status = acsp_pkg::ST_EMPTY;
		end else if (tn_d == 4'd0 || hm_q != acsp_pkg::HDR_SET) begin
			status = acsp_pkg::ST_NO_HDR;
		end else begin
			fields = (tn_d >= acsp_pkg::TOKEN_SAT) ? 3'd7 : 3'(tn_d - 4'd1);
			status = (fields == 3'd7) ? acsp_pkg::ST_ALL : acsp_pkg::ST_PARTIAL;
		end
		res.settings = set_d;
		res.fields   = fields;
		res.status   = status;

		// newline starts a fresh line
		if (step && is_lf) begin
			len_d   = '0;
			ended_d = 1'b0;
			tn_d    = 4'd0;
			intok_d = 1'b0;
			hm_d    = acsp_pkg::HDR_NONE;
			ph_d    = acsp_pkg::PH_SPACE;
			neg_d   = 1'b0;
			acc_d   = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			ended_q <= 1'b0;
			tn_q    <= 4'd0;
			intok_q <= 1'b0;
			hm_q    <= acsp_pkg::HDR_NONE;
			ph_q    <= acsp_pkg::PH_SPACE;
			neg_q   <= 1'b0;
			acc_q   <= 8'd0;
			set_q   <= '0;
		end else begin
			len_q   <= len_d;
			ended_q <= ended_d;
			tn_q    <= tn_d;
			intok_q <= intok_d;
			hm_q    <= hm_d;
			ph_q    <= ph_d;
			neg_q   <= neg_d;
			acc_q   <= acc_d;
			set_q   <= set_d;
		end
	end

endmodule

// ===== rtl/ascii_set_command_line_parser_core.sv =====
// A newline byte's result is loaded into the result register when the byte leaves the input register.
// Throughput: one byte per cycle; the input register holds a newline only
// while the result register still holds an earlier, untaken result.
// Other bytes never stall and produce no result transaction.
// Reset (arst_n low, asynchronous): pipeline empty, line state and all
// seven settings cleared to zero.
`timescale 1ns / 1ps

module ascii_set_command_line_parser_core #(
	parameter int LINE_LIMIT = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	// byte channel
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	// result channel
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] program_sel,
	output logic [7:0] brightness_level,
	output logic [7:0] speed_level,
	output logic [7:0] red_level,
	output logic [7:0] green_level,
	output logic [7:0] blue_level,
	output logic [7:0] extra_value,
	output logic [2:0] fields_updated,
	output logic [1:0] line_status
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              nl_s1;
	logic              advance;
	acsp_pkg::result_t res_next;
	acsp_pkg::result_t res_q;
	logic              res_valid_q;

	// A byte in the input register moves on unless it is a newline whose
	// result has nowhere to go.
	assign nl_s1    = (byte_s1 == acsp_pkg::CHAR_LF);
	assign advance  = valid_s1 && (!nl_s1 || !res_valid_q || result_ready);
	assign rx_ready = !valid_s1 || advance;

	// input register: hold while stalled, refill on every free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready)
			byte_s1 <= rx_byte;
	end

	// line parser: state advances once per byte leaving the input register
	acsp_line_state #(
		.LINE_LIMIT(LINE_LIMIT)
	) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_char (byte_s1),
		.res     (res_next)
	);

	// result register: load on a newline, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && nl_s1) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && nl_s1)
			res_q <= res_next;
	end

	assign result_valid     = res_valid_q;
	assign program_sel      = res_q.settings[0];
	assign brightness_level = res_q.settings[1];
	assign speed_level      = res_q.settings[2];
	assign red_level        = res_q.settings[3];
	assign green_level      = res_q.settings[4];
	assign blue_level       = res_q.settings[5];
	assign extra_value      = res_q.settings[6];
	assign fields_updated   = res_q.fields;
	assign line_status      = res_q.status;

endmodule

// ===== rtl/acsp_checker.sv =====
// acsp_checker: port-level checks on the SET parser core, bound to it below.
// Depends on acsp_pkg and ascii_set_command_line_parser_core.
`timescale 1ns / 1ps

module acsp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] program_sel,
	input logic [7:0] brightness_level,
	input logic [7:0] speed_level,
	input logic [7:0] red_level,
	input logic [7:0] green_level,
	input logic [7:0] blue_level,
	input logic [7:0] extra_value,
	input logic [2:0] fields_updated,
	input logic [1:0] line_status
);

	// a stalled result transaction holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			$stable(fields_updated) && $stable(line_status) &&
			$stable(program_sel) && $stable(brightness_level) &&
			$stable(speed_level) && $stable(red_level) &&
			$stable(green_level) && $stable(blue_level) && $stable(extra_value))
		else $error("result payload changed while stalled");

	// only a waiting result can hold off the byte channel
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> rx_ready)
		else $error("byte channel stalled with no result waiting");

	// empty or headerless lines write nothing
	a_no_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (line_status == acsp_pkg::ST_NO_HDR ||
			line_status == acsp_pkg::ST_EMPTY) |-> fields_updated == 3'd0)
		else $error("fields counted on a line without settings");

	// status agrees with the field count
	a_status_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			((line_status == acsp_pkg::ST_ALL) == (fields_updated == 3'd7)))
		else $error("line status disagrees with field count");

endmodule

bind ascii_set_command_line_parser_core acsp_checker u_acsp_checker (.*);

// ===== tb/tb_ascii_set_command_line_parser_core.sv =====
// Testbench for the SET command line parser core: byte stream in, one
// settings/status record out per newline, checked against a local predictor.
// Depends on rtl/acsp_pkg.sv and rtl/ascii_set_command_line_parser_core.sv.
`timescale 1ns / 1ps

module tb_ascii_set_command_line_parser_core;

	localparam int LINE_LIMIT  = 64;
	localparam int STALL_LIMIT = 2000;	// cycles with no transaction on either side
	localparam int END_SETTLE  = 10;	// extra wait after the last result is taken; leave some margin

	logic       clk;
	logic       arst_n;
	logic       rx_valid;
	logic       rx_ready;
	logic [7:0] rx_byte;
	logic       result_valid;
	logic       result_ready;
	logic [7:0] program_sel;
	logic [7:0] brightness_level;
	logic [7:0] speed_level;
	logic [7:0] red_level;
	logic [7:0] green_level;
	logic [7:0] blue_level;
	logic [7:0] extra_value;
	logic [2:0] fields_updated;
	logic [1:0] line_status;

	ascii_set_command_line_parser_core #(
		.LINE_LIMIT(LINE_LIMIT)
	) uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.rx_valid         (rx_valid),
		.rx_ready         (rx_ready),
		.rx_byte          (rx_byte),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.program_sel      (program_sel),
		.brightness_level (brightness_level),
		.speed_level      (speed_level),
		.red_level        (red_level),
		.green_level      (green_level),
		.blue_level       (blue_level),
		.extra_value      (extra_value),
		.fields_updated   (fields_updated),
		.line_status      (line_status)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Line predictor: its own copy of the per-line scan state and the
	// seven settings, advanced once per accepted byte.
	// ------------------------------------------------------------------
	int          ln_len;		// bytes kept in the current line
	bit          ln_done;		// a NUL was kept, rest of the line is dead text
	logic [3:0]  tok_cnt;		// tokens closed so far, saturates at TOKEN_SAT
	bit          tok_open;
	logic [2:0]  hdr_state;
	logic [1:0]  scan_phase;
	bit          tok_neg;
	logic [7:0]  tok_val;
	logic [7:0]  settings_now [acsp_pkg::SETTING_COUNT];

	acsp_pkg::result_t line_results [$];	// expected records, oldest first

	int          mismatches;
	int          bytes_sent;
	bit          tx_fast;		// sender runs back to back
	bit          rx_fast;		// receiver never stalls

	string setting_name [acsp_pkg::SETTING_COUNT] = '{"program_sel", "brightness_level",
		"speed_level", "red_level", "green_level", "blue_level", "extra_value"};

	function automatic void clear_line_state();
		ln_len     = 0;
		ln_done    = 1'b0;
		tok_cnt    = '0;
		tok_open   = 1'b0;
		hdr_state  = acsp_pkg::HDR_NONE;
		scan_phase = acsp_pkg::PH_SPACE;
		tok_neg    = 1'b0;
		tok_val    = '0;
	endfunction

	// Close the open token: the first one is the header, the next seven
	// land in the settings (only behind a good header), then the count saturates.
	function automatic void end_token();
		if (!tok_open)
			return;
		tok_open = 1'b0;
		if (tok_cnt == 0) begin
			tok_cnt = 4'd1;
		end else if (hdr_state == acsp_pkg::HDR_SET &&
				tok_cnt <= acsp_pkg::SETTING_COUNT) begin
			settings_now[tok_cnt - 1] = tok_neg ? (8'd0 - tok_val) : tok_val;
			tok_cnt = tok_cnt + 4'd1;
		end else if (tok_cnt <= acsp_pkg::SETTING_COUNT) begin
			tok_cnt = tok_cnt + 4'd1;
		end
	endfunction

	function automatic void scan_char(logic [7:0] c);
		if (c == acsp_pkg::CHAR_COMMA) begin
			end_token();
			return;
		end
		if (!tok_open) begin
			tok_open   = 1'b1;
			scan_phase = acsp_pkg::PH_SPACE;
			tok_neg    = 1'b0;
			tok_val    = '0;
		end
		// header token: must spell exactly SET
		if (tok_cnt == 0) begin
			if (hdr_state == acsp_pkg::HDR_NONE && c == acsp_pkg::CHAR_UP_S)
				hdr_state = acsp_pkg::HDR_S;
			else if (hdr_state == acsp_pkg::HDR_S && c == acsp_pkg::CHAR_UP_E)
				hdr_state = acsp_pkg::HDR_SE;
			else if (hdr_state == acsp_pkg::HDR_SE && c == acsp_pkg::CHAR_UP_T)
				hdr_state = acsp_pkg::HDR_SET;
			else
				hdr_state = acsp_pkg::HDR_BAD;
			return;
		end
		if (scan_phase == acsp_pkg::PH_STOP)
			return;
		if (scan_phase == acsp_pkg::PH_SPACE && (c == acsp_pkg::CHAR_SPACE ||
				c == acsp_pkg::CHAR_TAB || c == acsp_pkg::CHAR_VT ||
				c == acsp_pkg::CHAR_FF))
			return;
		if (scan_phase == acsp_pkg::PH_SPACE &&
				(c == acsp_pkg::CHAR_PLUS || c == acsp_pkg::CHAR_MINUS)) begin
			tok_neg    = (c == acsp_pkg::CHAR_MINUS);
			scan_phase = acsp_pkg::PH_SIGN;
			return;
		end
		if (c >= acsp_pkg::CHAR_ZERO && c <= acsp_pkg::CHAR_NINE) begin
			tok_val    = tok_val * 8'd10 + (c - acsp_pkg::CHAR_ZERO);
			scan_phase = acsp_pkg::PH_DIGIT;
			return;
		end
		scan_phase = acsp_pkg::PH_STOP;
	endfunction

	// Advance the predictor by one accepted byte; a newline queues a record.
	function automatic void predict_byte(logic [7:0] c);
		acsp_pkg::result_t rec;
		int                n;
		if (c == acsp_pkg::CHAR_CR)
			return;
		if (c != acsp_pkg::CHAR_LF) begin
			if (ln_len < LINE_LIMIT - 1) begin
				ln_len++;
				if (!ln_done) begin
					if (c == acsp_pkg::CHAR_NUL) begin
						end_token();
						ln_done = 1'b1;
					end else begin
						scan_char(c);
					end
				end
			end
			return;
		end
		if (!ln_done)
			end_token();
		rec.fields = '0;
		if (ln_len == 0) begin
			rec.status = acsp_pkg::ST_EMPTY;
		end else if (tok_cnt == 0 || hdr_state != acsp_pkg::HDR_SET) begin
			rec.status = acsp_pkg::ST_NO_HDR;
		end else begin
			n = tok_cnt - 1;
			if (n > acsp_pkg::SETTING_COUNT)
				n = acsp_pkg::SETTING_COUNT;
			rec.fields = n[2:0];
			rec.status = (n == acsp_pkg::SETTING_COUNT) ? acsp_pkg::ST_ALL :
				acsp_pkg::ST_PARTIAL;
		end
		for (int i = 0; i < acsp_pkg::SETTING_COUNT; i++)
			rec.settings[i] = settings_now[i];
		line_results.push_back(rec);
		clear_line_state();
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Result checker: compare every result transaction with the oldest
	// expected record, field by field.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		acsp_pkg::result_t want;
		acsp_pkg::result_t got;
		if (arst_n && result_valid && result_ready) begin
			got.settings[0] = program_sel;
			got.settings[1] = brightness_level;
			got.settings[2] = speed_level;
			got.settings[3] = red_level;
			got.settings[4] = green_level;
			got.settings[5] = blue_level;
			got.settings[6] = extra_value;
			got.fields      = fields_updated;
			got.status      = line_status;
			if (line_results.size() == 0) begin
				report_mismatch("result transaction with no line pending");
			end else begin
				want = line_results.pop_front();
				for (int i = 0; i < acsp_pkg::SETTING_COUNT; i++)
					if (got.settings[i] !== want.settings[i])
						report_mismatch($sformatf("%s got %0d expected %0d",
							setting_name[i], got.settings[i], want.settings[i]));
				if (got.fields !== want.fields)
					report_mismatch($sformatf("fields_updated got %0d expected %0d",
						got.fields, want.fields));
				if (got.status !== want.status)
					report_mismatch($sformatf("line_status got %0d expected %0d",
						got.status, want.status));
			end
		end
	end

	// Watchdog: a run that stops moving on both channels is a failure.
	int idle_cycles;
	always @(posedge clk) begin
		if (!arst_n || (rx_valid && rx_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= STALL_LIMIT) begin
			$display("[%0t] watchdog: no transaction for %0d cycles", $realtime,
				STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: per result draw a stall, then hold ready until a transaction.
	initial begin
		int stall;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_fast ? 0 : $urandom_range(0, 19);
			@(negedge clk);
			if (stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid && result_ready));
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Send one byte: optional gap, then hold valid and data until taken.
	// Valid stays high across back-to-back bytes.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 19);
		@(negedge clk);
		if (gap != 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!rx_ready);
		predict_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Hold off the sender until every pending line has been answered.
	task automatic drain_results();
		@(negedge clk);
		rx_valid <= 1'b0;
		while (line_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_space();
		case ($urandom_range(0, 3))
			0: return acsp_pkg::CHAR_SPACE;
			1: return acsp_pkg::CHAR_TAB;
			2: return acsp_pkg::CHAR_VT;
			default: return acsp_pkg::CHAR_FF;
		endcase
	endfunction

	// Mostly well-formed SET lines with random numbers, some damaged.
	task automatic send_random_line();
		logic [7:0] q [$];
		int form;
		int ntok;
		int ndig;
		int pos;
		form = $urandom_range(0, 11);
		if (form < 9) begin
			q.push_back(acsp_pkg::CHAR_UP_S);
			q.push_back(acsp_pkg::CHAR_UP_E);
			q.push_back(acsp_pkg::CHAR_UP_T);
		end else if (form == 9) begin
			q.push_back(acsp_pkg::CHAR_UP_S);
			q.push_back(acsp_pkg::CHAR_UP_E);
			q.push_back(8'($urandom_range(8'h41, 8'h5A)));
		end else if (form == 10) begin
			repeat ($urandom_range(1, 4))
				q.push_back(8'($urandom_range(8'h21, 8'h7E)));
		end
		ntok = ($urandom_range(0, 2) != 0) ? acsp_pkg::SETTING_COUNT :
			$urandom_range(0, 10);
		for (int k = 0; k < ntok; k++) begin
			q.push_back(acsp_pkg::CHAR_COMMA);
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 2)) q.push_back(acsp_pkg::CHAR_COMMA);
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
				q.push_back(pick_space());
			case ($urandom_range(0, 5))
				0: q.push_back(acsp_pkg::CHAR_MINUS);
				1: q.push_back(acsp_pkg::CHAR_PLUS);
				default: ;
			endcase
			ndig = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
			repeat (ndig) q.push_back(acsp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
			if ($urandom_range(0, 9) == 0)
				q.push_back(8'($urandom_range(8'h21, 8'h7E)));
		end
		if ($urandom_range(0, 9) == 0)
			q.push_back(acsp_pkg::CHAR_COMMA);
		if (q.size() != 0 && $urandom_range(0, 19) == 0) begin
			pos = $urandom_range(0, q.size() - 1);
			q.insert(pos, acsp_pkg::CHAR_NUL);
		end
		if ($urandom_range(0, 2) == 0)
			q.push_back(acsp_pkg::CHAR_CR);
		q.push_back(acsp_pkg::CHAR_LF);
		foreach (q[i])
			send_byte(q[i]);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_empty_lines();
		send_byte(acsp_pkg::CHAR_LF);
		send_byte(acsp_pkg::CHAR_CR);
		send_byte(acsp_pkg::CHAR_LF);
	endtask

	task automatic test_full_lines();
		send_text("SET,1,2,3,4,5,6,7\r\n");
		send_text("SET,255,0,128,127,-128,-1,256\n");
	endtask

	task automatic test_headers();
		send_text("SEX,9\n");
		send_text("SETT,9\n");
		send_text(",,,\n");
		send_text("SET\n");
		send_text(",,SET,,4,,,5\n");
	endtask

	task automatic test_number_forms();
		// leading blanks of every kind, signs, a stop at a non-digit,
		// a token with no digits and a bare sign
		send_text("SET, ");
		send_byte(acsp_pkg::CHAR_TAB);
		send_byte(acsp_pkg::CHAR_VT);
		send_byte(acsp_pkg::CHAR_FF);
		send_text("-12,+300,1a5,abc,-,+7x,2 5\n");
	endtask

	task automatic test_zero_byte();
		send_text("SET,5,6");
		send_byte(acsp_pkg::CHAR_NUL);
		send_text(",7\n");
		send_byte(acsp_pkg::CHAR_NUL);
		send_byte(acsp_pkg::CHAR_LF);
	endtask

	task automatic test_line_overflow();
		// the tail past the kept length must be dropped
		send_text("SET,11,22,");
		repeat (60) send_byte(acsp_pkg::CHAR_SPACE);
		send_text(",44,55\n");
	endtask

	task automatic test_extra_tokens();
		send_text("SET,1,2,3,4,5,6,7,8,9\n");
	endtask

	task automatic test_random_lines();
		int stop_at;
		stop_at = bytes_sent + 420;
		while (bytes_sent < stop_at) begin
			// alternate between full-speed stretches and random idling
			tx_fast = ($urandom_range(0, 3) == 0);
			rx_fast = ($urandom_range(0, 3) == 0);
			send_random_line();
		end
		tx_fast = 1'b0;
		rx_fast = 1'b0;
	endtask

	task automatic test_random_noise();
		repeat (200) begin
			if ($urandom_range(0, 11) == 0)
				send_byte(acsp_pkg::CHAR_LF);
			else
				send_byte(8'($urandom_range(0, 255)));
		end
		send_byte(acsp_pkg::CHAR_LF);
	endtask

	initial begin
		arst_n       = 1'b0;
		rx_valid     = 1'b0;
		rx_byte      = '0;
		mismatches   = 0;
		bytes_sent   = 0;
		tx_fast      = 1'b0;
		rx_fast      = 1'b0;
		clear_line_state();
		for (int i = 0; i < acsp_pkg::SETTING_COUNT; i++)
			settings_now[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_lines();
		test_full_lines();
		test_headers();
		drain_results();
		test_number_forms();
		test_zero_byte();
		test_line_overflow();
		test_extra_tokens();
		drain_results();
		test_random_lines();
		test_random_noise();

		// drop valid and wait out the last results
		drain_results();
		repeat (END_SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
